// ===== src/brw_pkg.sv =====
// ----------------------------------------------------------------------------
// Block reconstruction write-back package
// Shared beat types, register indexes, code names and the block placement
// tables used by the pipeline stages.
// ----------------------------------------------------------------------------
package brw_pkg;

    localparam int FW_W     = 12;   // frame_width register
    localparam int LINE_W   = 12;   // line number inside the plane
    localparam int COL_W    = 12;   // column inside the plane
    localparam int OFFS_W   = 22;   // byte offset in the plane
    localparam int PROD_W   = LINE_W + FW_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int LAST_BLOCK = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_CHROMA_MODE  = 2'd1,
        REG_PICTURE_MODE = 2'd2,
        REG_UNUSED       = 2'd3
    } reg_index_t;

    localparam logic [1:0] CF_NONE = 2'd0;
    localparam logic [1:0] CF_420  = 2'd1;
    localparam logic [1:0] CF_422  = 2'd2;
    localparam logic [1:0] CF_444  = 2'd3;

    localparam logic [1:0] PS_NONE   = 2'd0;
    localparam logic [1:0] PS_TOP    = 2'd1;
    localparam logic [1:0] PS_BOTTOM = 2'd2;
    localparam logic [1:0] PS_FRAME  = 2'd3;

    localparam logic [1:0] PLANE_Y  = 2'd0;
    localparam logic [1:0] PLANE_CB = 2'd1;
    localparam logic [1:0] PLANE_CR = 2'd2;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 12'd720;

    typedef struct packed {
        logic signed [9:0] residual;
        logic [7:0]        prediction_pixel;
        logic              intra_flag;
        logic [3:0]        block_index;
        logic [10:0]       mb_x;
        logic [10:0]       mb_y;
        logic              field_dct;
        logic [2:0]        row_in_block;
        logic [2:0]        col_in_block;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        plane_select;
        logic [OFFS_W-1:0] pixel_offset;
        logic [7:0]        pixel_value;
    } out_beat_t;

    typedef struct packed {
        logic [FW_W-1:0] frame_width;
        logic [1:0]      chroma_mode;
        logic [1:0]      picture_mode;
    } cfg_t;

    // After decode: plane line number and column, still to be scaled.
    typedef struct packed {
        logic [1:0]        plane_select;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [7:0]        pixel_value;
    } dec_beat_t;

    // After the multiplier: line start offset, column still to be added.
    typedef struct packed {
        logic [1:0]        plane_select;
        logic [OFFS_W-1:0] line_base;
        logic [COL_W-1:0]  column;
        logic [7:0]        pixel_value;
    } mul_beat_t;

    function automatic logic [1:0] plane_of_block(input logic [3:0] blk);
        logic [1:0] p;
        case (blk)
            4'd0, 4'd1, 4'd2, 4'd3:    p = PLANE_Y;
            4'd4, 4'd6, 4'd8, 4'd10:   p = PLANE_CB;
            4'd5, 4'd7, 4'd9, 4'd11:   p = PLANE_CR;
            default:                   p = PLANE_Y;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] col_off_of_block(input logic [3:0] blk);
        logic [3:0] c;
        case (blk)
            4'd1, 4'd3, 4'd8, 4'd9, 4'd10, 4'd11: c = 4'd8;
            default:                              c = 4'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] lower_line_off(input logic [1:0] ps, input logic dct);
        logic [4:0] o;
        case (ps)
            PS_NONE:   o = 5'd0;
            PS_TOP:    o = 5'd16;
            PS_BOTTOM: o = 5'd17;
            PS_FRAME:  o = dct ? 5'd1 : 5'd8;
            default:   o = 5'd0;
        endcase
        return o;
    endfunction

    function automatic logic [4:0] upper_line_off(input logic [1:0] ps);
        logic [4:0] o;
        case (ps)
            PS_BOTTOM: o = 5'd1;
            default:   o = 5'd0;
        endcase
        return o;
    endfunction

endpackage

// ===== src/brw_decode.sv =====
// ----------------------------------------------------------------------------
// Block reconstruction decode stage
// Places the sample in its plane (line and column before scaling by the
// line length) and reconstructs the clipped pixel value.
// ----------------------------------------------------------------------------
module brw_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  brw_pkg::cfg_t        cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  brw_pkg::in_beat_t    in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output brw_pkg::dec_beat_t   out_beat
);
    import brw_pkg::*;

    logic        valid_reg;
    dec_beat_t   beat_reg;
    dec_beat_t   beat_next;
    logic        keep;
    logic [1:0]  plane;
    logic        xs;
    logic        ys;
    logic        ss;
    logic [4:0]  yoff;
    logic [10:0] y_scaled;
    logic [10:0] x_scaled;
    logic signed [10:0] sum;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Blocks beyond the last index are swallowed without a result.
    assign keep = in_beat.block_index <= 4'(LAST_BLOCK);

    always_comb begin
        plane = plane_of_block(in_beat.block_index);
        xs = (plane != PLANE_Y) &&
             (cfg.chroma_mode == CF_420 || cfg.chroma_mode == CF_422);
        ys = (plane != PLANE_Y) && (cfg.chroma_mode == CF_420);

        ss = 1'b0;
        if (cfg.chroma_mode != CF_NONE && cfg.picture_mode != PS_NONE) begin
            if (cfg.picture_mode != PS_FRAME) begin
                ss = 1'b1;
            end else if (plane == PLANE_Y || cfg.chroma_mode == CF_422 ||
                         cfg.chroma_mode == CF_444) begin
                ss = in_beat.field_dct;
            end
        end

        yoff = in_beat.block_index[1]
             ? lower_line_off(cfg.picture_mode, in_beat.field_dct)
             : upper_line_off(cfg.picture_mode);

        y_scaled = ys ? (in_beat.mb_y >> 1) : in_beat.mb_y;
        x_scaled = xs ? (in_beat.mb_x >> 1) : in_beat.mb_x;

        // Rows step by one or two lines; folding them into the line number
        // leaves a single multiply by the line length.
        beat_next.plane_select = plane;
        beat_next.line   = LINE_W'(y_scaled) + LINE_W'(yoff)
                         + (LINE_W'(in_beat.row_in_block) << ss);
        beat_next.column = COL_W'(x_scaled) + COL_W'(col_off_of_block(in_beat.block_index))
                         + COL_W'(in_beat.col_in_block);

        sum = in_beat.intra_flag ? 11'(in_beat.residual)
            : 11'(in_beat.residual) + $signed({3'b000, in_beat.prediction_pixel});
        if (sum < 0) begin
            beat_next.pixel_value = 8'd0;
        end else if (sum > 11'sd255) begin
            beat_next.pixel_value = 8'd255;
        end else begin
            beat_next.pixel_value = sum[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ===== src/brw_scale.sv =====
// ----------------------------------------------------------------------------
// Block reconstruction line scaling stage
// Multiplies the plane line number by the line length to give the byte
// offset of the line start.
// ----------------------------------------------------------------------------
module brw_scale (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [brw_pkg::FW_W-1:0]      frame_width,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  brw_pkg::dec_beat_t            in_beat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output brw_pkg::mul_beat_t            out_beat
);
    import brw_pkg::*;

    logic              valid_reg;
    mul_beat_t         beat_reg;
    mul_beat_t         beat_next;
    logic [PROD_W-1:0] product;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        product = PROD_W'(in_beat.line) * PROD_W'(frame_width);
        beat_next.plane_select = in_beat.plane_select;
        beat_next.line_base    = product[OFFS_W-1:0];
        beat_next.column       = in_beat.column;
        beat_next.pixel_value  = in_beat.pixel_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ===== src/brw_output.sv =====
// ----------------------------------------------------------------------------
// Block reconstruction output stage
// Adds the column to the line start, wrapping in the offset width, and holds
// the result beat for the downstream side.
// ----------------------------------------------------------------------------
module brw_output (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  brw_pkg::mul_beat_t   in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output brw_pkg::out_beat_t   out_beat
);
    import brw_pkg::*;

    logic        valid_reg;
    out_beat_t   beat_reg;
    out_beat_t   beat_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    always_comb begin
        beat_next.plane_select = in_beat.plane_select;
        beat_next.pixel_offset = in_beat.line_base + OFFS_W'(in_beat.column);
        beat_next.pixel_value  = in_beat.pixel_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            beat_reg <= beat_next;
        end
    end

endmodule

// ===== src/block_reconstruction_writeback.sv =====
// ----------------------------------------------------------------------------
// Block reconstruction write-back
// Places one reconstructed sample of an 8x8 block in its Y, Cb or Cr plane
// and returns the plane, the byte offset and the clipped pixel.
//
//   Port group   Direction  Content
//   s_*          in         one sample with its macroblock context
//   m_*          out        plane, byte offset in the plane, pixel value
//   cfg_*        in         register write, no wait and no read-back
//
// One beat is taken every cycle unless a stall on m_ready has filled every
// stage. The depth is set by decode, the line-length multiplier and the
// offset adder, one register stage each.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on m_ready holds the output stage and each full stage directly behind it; empty stages still fill.
// Beats with a block index above eleven give no result.
// ----------------------------------------------------------------------------
module block_reconstruction_writeback (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  brw_pkg::in_beat_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output brw_pkg::out_beat_t                 m_data,
    input  logic                               cfg_wr_en,
    input  logic [brw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [brw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import brw_pkg::*;

    cfg_t       cfg_reg;
    dec_beat_t  dec_beat;
    mul_beat_t  mul_beat;
    logic       dec_valid;
    logic       dec_ready;
    logic       mul_valid;
    logic       mul_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RESET;
            cfg_reg.chroma_mode  <= CF_420;
            cfg_reg.picture_mode <= PS_FRAME;
        end else if (cfg_wr_en) begin
            case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_wdata[FW_W-1:0];
                REG_CHROMA_MODE:  cfg_reg.chroma_mode  <= cfg_wdata[1:0];
                REG_PICTURE_MODE: cfg_reg.picture_mode <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    brw_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_beat   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_beat  (dec_beat)
    );

    brw_scale u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_width (cfg_reg.frame_width),
        .in_valid    (dec_valid),
        .in_ready    (dec_ready),
        .in_beat     (dec_beat),
        .out_valid   (mul_valid),
        .out_ready   (mul_ready),
        .out_beat    (mul_beat)
    );

    brw_output u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .in_beat   (mul_beat),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_beat  (m_data)
    );

endmodule

// ===== test/block_reconstruction_writeback_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block reconstruction write-back testbench
// Sends sample beats with their macroblock context through the block and
// checks every result beat against an independent prediction of the plane,
// the byte offset and the clipped pixel. The run covers several register
// settings, input bursts with random gaps and a receiver that stalls.
// ----------------------------------------------------------------------------
module block_reconstruction_writeback_tb;
    import brw_pkg::*;

    localparam int LIMIT_CYCLES    = 300000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int NUM_PHASES      = 7;
    localparam int REPORT_LIMIT    = 10;

    class pixel_scoreboard;
        out_beat_t       expected_pixels[$];
        logic [FW_W-1:0] frame_width;
        logic [1:0]      chroma_mode;
        logic [1:0]      picture_mode;
        int              mismatches;

        function new();
            frame_width  = FRAME_WIDTH_RESET;
            chroma_mode  = CF_420;
            picture_mode = PS_FRAME;
            mismatches   = 0;
        endfunction

        function void write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH:  frame_width = value[FW_W-1:0];
                REG_CHROMA_MODE:  chroma_mode = value[1:0];
                REG_PICTURE_MODE: picture_mode = value[1:0];
                default: ;
            endcase
        endfunction

        function out_beat_t place_pixel(in_beat_t s);
            out_beat_t   r;
            logic [3:0]  blk;
            int unsigned xs, ys, ss, yoff, col_off, line_step, offset, fw;
            int unsigned x, y, row, col;
            int          v;
            blk = s.block_index;
            fw  = frame_width;
            x   = s.mb_x;
            y   = s.mb_y;
            row = s.row_in_block;
            col = s.col_in_block;
            r.plane_select = (blk < 4) ? PLANE_Y : (blk[0] ? PLANE_CR : PLANE_CB);
            col_off = ((blk < 4 && blk[0]) || blk >= 8) ? 8 : 0;
            xs = 0;
            ys = 0;
            ss = 0;
            // Chroma is subsampled horizontally for 4:2:0 and 4:2:2, vertically for 4:2:0.
            if (r.plane_select != PLANE_Y) begin
                xs = (chroma_mode == CF_420 || chroma_mode == CF_422) ? 1 : 0;
                ys = (chroma_mode == CF_420) ? 1 : 0;
            end
            if (chroma_mode != CF_NONE && picture_mode != PS_NONE) begin
                if (picture_mode != PS_FRAME) begin
                    ss = 1;
                end else if (r.plane_select == PLANE_Y || chroma_mode != CF_420) begin
                    ss = s.field_dct;
                end
            end
            if (blk[1]) begin
                case (picture_mode)
                    PS_TOP:    yoff = 16;
                    PS_BOTTOM: yoff = 17;
                    PS_FRAME:  yoff = s.field_dct ? 1 : 8;
                    default:   yoff = 0;
                endcase
            end else begin
                yoff = (picture_mode == PS_BOTTOM) ? 1 : 0;
            end
            line_step = fw << ss;
            offset = ((y >> ys) + yoff) * fw + (x >> xs) + col_off + row * line_step + col;
            r.pixel_offset = offset[OFFS_W-1:0];
            v = s.intra_flag ? 0 : int'(s.prediction_pixel);
            v = v + int'($signed(s.residual));
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            r.pixel_value = v[7:0];
            return r;
        endfunction

        function void note_sample(in_beat_t s);
            if (s.block_index <= LAST_BLOCK) expected_pixels.push_back(place_pixel(s));
        endfunction

        function void report_mismatch(string what, out_beat_t want, out_beat_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s: plane %0d/%0d offset %0d/%0d pixel %0d/%0d (expected/actual)",
                         $realtime, what, want.plane_select, got.plane_select,
                         want.pixel_offset, got.pixel_offset,
                         want.pixel_value, got.pixel_value);
            end
        endfunction

        function void check_pixel(out_beat_t got);
            out_beat_t want;
            if (expected_pixels.size() == 0) begin
                want = '0;
                report_mismatch("result beat with nothing outstanding", want, got);
                return;
            end
            want = expected_pixels.pop_front();
            if (got.plane_select !== want.plane_select ||
                got.pixel_offset !== want.pixel_offset ||
                got.pixel_value !== want.pixel_value) begin
                report_mismatch("result beat differs", want, got);
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_beat_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b1;
    out_beat_t              m_data;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    pixel_scoreboard        sb = new();
    int                     cycle_count = 0;
    logic [7:0]             ready_pattern = 8'hFF;
    int                     pattern_left = 0;

    block_reconstruction_writeback u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_sample(s_data);
            if (m_valid && m_ready) sb.check_pixel(m_data);
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("block_reconstruction_writeback verification failed");
            $finish;
        end
    end

    // The receiver rotates an 8-bit ready pattern and redraws it when pattern_left runs out.
    always @(negedge aclk) begin
        if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 8'hFF;
                1:       ready_pattern = 8'h01;
                default: ready_pattern = 8'($urandom_range(1, 255));
            endcase
            pattern_left = 64;
        end
        m_ready = ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
        pattern_left--;
    end

    task automatic send_sample(input in_beat_t b);
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic pause_input(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_register(idx, value);
    endtask

    // Waits until every expected pixel has come back, then lets dropped beats clear.
    task automatic settle();
        pause_input(1);
        while (sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic in_beat_t make_sample(int residual, int pred, int intra, int blk,
                                             int x, int y, int dct, int row, int col);
        in_beat_t b;
        b.residual         = residual[9:0];
        b.prediction_pixel = pred[7:0];
        b.intra_flag       = intra[0];
        b.block_index      = blk[3:0];
        b.mb_x             = x[10:0];
        b.mb_y             = y[10:0];
        b.field_dct        = dct[0];
        b.row_in_block     = row[2:0];
        b.col_in_block     = col[2:0];
        return b;
    endfunction

    function automatic in_beat_t random_sample();
        in_beat_t b;
        b.residual         = 10'($urandom);
        b.prediction_pixel = 8'($urandom);
        b.intra_flag       = 1'($urandom);
        b.block_index      = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(12, 15))
                                                          : 4'($urandom_range(0, 11));
        b.mb_x             = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                         : 11'($urandom_range(0, 127) * 16);
        b.mb_y             = ($urandom_range(0, 3) == 0) ? 11'($urandom)
                                                         : 11'($urandom_range(0, 127) * 16);
        b.field_dct        = 1'($urandom);
        b.row_in_block     = 3'($urandom);
        b.col_in_block     = 3'($urandom);
        return b;
    endfunction

    // One row of a block as a decoder would emit it: shared context, small residuals.
    task automatic send_block_row(input bit gaps);
        in_beat_t ctx;
        in_beat_t b;
        ctx = random_sample();
        ctx.block_index = 4'($urandom_range(0, LAST_BLOCK));
        for (int c = 0; c < 8; c++) begin
            b = ctx;
            b.col_in_block = c[2:0];
            b.residual = 10'(int'($urandom_range(0, 95)) - 48);
            send_sample(b);
        end
        if (gaps) pause_input($urandom_range(1, 6));
    endtask

    task automatic send_phase(input int count, input bit gaps);
        in_beat_t b;
        int       left;
        int       burst;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 2) == 0) begin
                send_block_row(gaps);
                left -= 8;
            end else begin
                burst = $urandom_range(1, 16);
                repeat (burst) begin
                    b = random_sample();
                    send_sample(b);
                    if (b.block_index <= LAST_BLOCK) left--;
                end
                if (gaps) pause_input($urandom_range(1, 6));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Clip limits, every block, dropped block numbers and position extremes.
        send_sample(make_sample(-512, 0, 1, 0, 0, 0, 0, 0, 0));
        send_sample(make_sample(511, 0, 1, 1, 2047, 2047, 1, 7, 7));
        send_sample(make_sample(-512, 255, 0, 2, 0, 2047, 0, 7, 0));
        send_sample(make_sample(511, 255, 0, 3, 2047, 0, 1, 0, 7));
        send_sample(make_sample(0, 255, 0, 4, 16, 16, 0, 3, 4));
        send_sample(make_sample(-1, 0, 0, 5, 32, 32, 1, 1, 1));
        send_sample(make_sample(1, 254, 0, 6, 2032, 2032, 0, 7, 7));
        send_sample(make_sample(100, 100, 1, 7, 48, 64, 1, 2, 5));
        send_sample(make_sample(-100, 50, 0, 8, 704, 560, 0, 4, 3));
        send_sample(make_sample(255, 0, 0, 9, 2047, 2047, 1, 7, 7));
        send_sample(make_sample(-256, 255, 0, 10, 0, 0, 1, 0, 0));
        send_sample(make_sample(0, 0, 1, 11, 1024, 1024, 0, 5, 6));
        send_sample(make_sample(10, 10, 0, 12, 16, 16, 0, 0, 0));
        send_sample(make_sample(10, 10, 0, 15, 2047, 2047, 1, 7, 7));
        send_sample(make_sample(0, 128, 0, 0, 2047, 2047, 1, 7, 7));
        send_sample(make_sample(-512, 255, 1, 2, 0, 0, 1, 7, 0));
        send_sample(make_sample(511, 0, 0, 11, 2047, 2047, 1, 7, 7));
        send_sample(make_sample(0, 0, 0, 6, 0, 0, 1, 0, 0));
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1: begin
                    write_register(REG_FRAME_WIDTH, 12'd16);
                    write_register(REG_CHROMA_MODE, {10'($urandom), CF_420});
                    write_register(REG_PICTURE_MODE, {10'($urandom), PS_TOP});
                end
                2: begin
                    write_register(REG_FRAME_WIDTH, 12'd4095);
                    write_register(REG_CHROMA_MODE, {10'($urandom), CF_444});
                    write_register(REG_PICTURE_MODE, {10'($urandom), PS_BOTTOM});
                end
                3: begin
                    write_register(REG_FRAME_WIDTH, 12'd2048);
                    write_register(REG_CHROMA_MODE, {10'($urandom), CF_422});
                    write_register(REG_PICTURE_MODE, {10'($urandom), PS_FRAME});
                end
                4: begin
                    write_register(REG_FRAME_WIDTH, 12'd0);
                    write_register(REG_CHROMA_MODE, {10'($urandom), CF_NONE});
                    write_register(REG_UNUSED, 12'($urandom));
                end
                5: begin
                    write_register(REG_FRAME_WIDTH, 12'($urandom_range(16, 2048)));
                    write_register(REG_CHROMA_MODE, {10'($urandom), 2'($urandom_range(1, 3))});
                    write_register(REG_PICTURE_MODE, {10'($urandom), PS_NONE});
                end
                6: begin
                    write_register(REG_FRAME_WIDTH, 12'($urandom));
                    write_register(REG_CHROMA_MODE, 12'($urandom));
                    write_register(REG_PICTURE_MODE, 12'($urandom));
                end
                default: ;
            endcase
            // Phase three runs without input gaps so the pipeline stays full.
            send_phase(ITEMS_PER_PHASE, p != 3);
            settle();
        end

        if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
            $display("block_reconstruction_writeback verification clean");
        end else begin
            $display("block_reconstruction_writeback verification failed");
        end
        $finish;
    end

endmodule
